// ===== rtl/dthbi_pkg.sv =====
package dthbi_pkg;

  localparam int COORD_W   = 16;
  localparam int ANG_FRAC  = 8;
  localparam int STEPS     = 24;
  localparam int STEP_W    = $clog2(STEPS);
  localparam int ACC_FRAC  = 24;
  localparam int GUARD     = 20;
  localparam int NUM_RINGS = 14;
  localparam int RING_W    = 4;
  localparam int AZI_W     = 7;
  localparam int ENTRY_W   = 10;

  localparam logic [30:0] GAIN_Q30 = 31'd1768195363;
  localparam int GAIN_SHIFT = 30 - GUARD;

  // cordic datapath widths
  localparam int CW = COORD_W + 1 + GUARD + 4;
  localparam int AW = ACC_FRAC + 11;
  localparam int RND_SHIFT = ACC_FRAC - ANG_FRAC;
  localparam int EW = AW - RND_SHIFT;

  localparam int FULL  = 360 << ANG_FRAC;
  localparam int AZW   = $clog2(FULL);
  localparam int HALF_TURN = 180;
  localparam int TEN   = 10 << ANG_FRAC;
  localparam int RING_OFS = 4;

  // bin index divide: (2*az*n + full) / (2*full), 2*full = 45 << (ANG_FRAC + 4)
  localparam int PROD_W   = AZW + AZI_W + 2;
  localparam int DIV_SHIFT = ANG_FRAC + 4;
  localparam int Q_W       = PROD_W - DIV_SHIFT;
  localparam int RECIP45   = 2913;
  localparam int RECIP_SH  = 17;
  localparam int RECIP5    = 13;
  localparam int RECIP5_SH = 6;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
  } cordic_t;

  function automatic logic signed [AW-1:0] atan_deg(input logic [STEP_W-1:0] i);
    logic signed [AW-1:0] r;
    unique case (i)
      5'd0:  r = AW'(754974720);
      5'd1:  r = AW'(445687602);
      5'd2:  r = AW'(235489088);
      5'd3:  r = AW'(119537938);
      5'd4:  r = AW'(60000934);
      5'd5:  r = AW'(30029717);
      5'd6:  r = AW'(15018523);
      5'd7:  r = AW'(7509720);
      5'd8:  r = AW'(3754917);
      5'd9:  r = AW'(1877466);
      5'd10: r = AW'(938734);
      5'd11: r = AW'(469367);
      5'd12: r = AW'(234684);
      5'd13: r = AW'(117342);
      5'd14: r = AW'(58671);
      5'd15: r = AW'(29335);
      5'd16: r = AW'(14668);
      5'd17: r = AW'(7334);
      5'd18: r = AW'(3667);
      5'd19: r = AW'(1833);
      5'd20: r = AW'(917);
      5'd21: r = AW'(458);
      5'd22: r = AW'(229);
      5'd23: r = AW'(115);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [AZI_W-1:0] ring_size(input logic [RING_W-1:0] r);
    logic [AZI_W-1:0] n;
    unique case (r)
      4'd0:  n = 7'd56;
      4'd1:  n = 7'd60;
      4'd2:  n = 7'd72;
      4'd3:  n = 7'd72;
      4'd4:  n = 7'd72;
      4'd5:  n = 7'd72;
      4'd6:  n = 7'd72;
      4'd7:  n = 7'd60;
      4'd8:  n = 7'd56;
      4'd9:  n = 7'd45;
      4'd10: n = 7'd36;
      4'd11: n = 7'd24;
      4'd12: n = 7'd12;
      4'd13: n = 7'd1;
      default: n = 7'd1;
    endcase
    return n;
  endfunction

  function automatic logic [ENTRY_W-1:0] ring_base(input logic [RING_W-1:0] r);
    logic [ENTRY_W-1:0] b;
    unique case (r)
      4'd0:  b = 10'd0;
      4'd1:  b = 10'd56;
      4'd2:  b = 10'd116;
      4'd3:  b = 10'd188;
      4'd4:  b = 10'd260;
      4'd5:  b = 10'd332;
      4'd6:  b = 10'd404;
      4'd7:  b = 10'd476;
      4'd8:  b = 10'd536;
      4'd9:  b = 10'd592;
      4'd10: b = 10'd637;
      4'd11: b = 10'd673;
      4'd12: b = 10'd697;
      4'd13: b = 10'd709;
      default: b = 10'd709;
    endcase
    return b;
  endfunction

  // round to ANG_FRAC fractional bits, half away from zero
  function automatic logic signed [AW-1:0] round_ang(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] half;
    half = AW'(1) <<< (RND_SHIFT - 1);
    if (a >= 0) begin
      return (a + half) >>> RND_SHIFT;
    end else begin
      return -((-a + half) >>> RND_SHIFT);
    end
  endfunction

endpackage

// ===== rtl/dthbi_if.sv =====
interface dthbi_req_if;
  import dthbi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic                      ear_sel;
  modport source (output valid, pos_x, pos_y, pos_z, ear_sel, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, ear_sel, output ready);
endinterface

interface dthbi_rsp_if;
  import dthbi_pkg::*;
  logic               valid;
  logic               ready;
  logic               ear_out;
  logic [RING_W-1:0]  elev_index;
  logic [AZI_W-1:0]   azim_index;
  logic [ENTRY_W-1:0] entry_number;
  logic               zero_vector;
  modport source (output valid, ear_out, elev_index, azim_index, entry_number, zero_vector,
                  input ready);
  modport sink   (input valid, ear_out, elev_index, azim_index, entry_number, zero_vector,
                  output ready);
endinterface

// ===== rtl/dthbi_cordic_stage.sv =====
module dthbi_cordic_stage (
  input  logic                        clk,
  input  logic                        en,
  input  logic [dthbi_pkg::STEP_W-1:0] step,
  input  dthbi_pkg::cordic_t          d_in,
  output dthbi_pkg::cordic_t          d_out
);
  import dthbi_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [AW-1:0] da;

  assign dx = d_in.y >>> step;
  assign dy = d_in.x >>> step;
  assign da = atan_deg(step);

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (en) begin
      if (d_in.y >= 0) begin
        d_out.x   <= d_in.x + dx;
        d_out.y   <= d_in.y - dy;
        d_out.acc <= d_in.acc + da;
      end else begin
        d_out.x   <= d_in.x - dx;
        d_out.y   <= d_in.y + dy;
        d_out.acc <= d_in.acc - da;
      end
    end
  end

endmodule

// ===== rtl/direction_to_hrtf_bin_index.sv =====
// channel  modport  payload                                              role
// req      sink     pos_x, pos_y, pos_z, ear_sel                         direction in
// rsp      source   ear_out, elev_index, azim_index, entry_number,       grid entry out
//                   zero_vector
// cfg      write    cfg_we, cfg_wdata                                    orientation_mode
//
// one transaction per cycle sustained while rsp is not stalled, 54 register stages
// most stages come from two chained 24-step cordic pipelines (azimuth, then elevation)
// rst is synchronous: clears valid bits and orientation_mode
// a stalled rsp holds the whole pipeline; req.ready = !rsp.valid || rsp.ready
module direction_to_hrtf_bin_index (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  dthbi_req_if.sink         req,
  dthbi_rsp_if.source       rsp
);
  import dthbi_pkg::*;

  logic en;
  logic orient;

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      orient <= 1'b0;
    end else if (cfg_we) begin
      orient <= cfg_wdata;
    end
  end

  // input prep: apply orientation, fold to the right half plane, take |z|
  logic signed [COORD_W:0] sx, sy, tx, ty, sz;
  logic                    s_neg;
  always_comb begin
    sx = (COORD_W+1)'(req.pos_x);
    sy = (COORD_W+1)'(req.pos_y);
    sz = (COORD_W+1)'(req.pos_z);
    tx = orient ? sy : sx;
    ty = orient ? -sx : sy;
    s_neg = tx < 0;
    if (s_neg) begin
      tx = -tx;
      ty = -ty;
    end
    if (sz < 0) begin
      sz = -sz;
    end
  end

  logic                    v0;
  logic signed [COORD_W:0] ax0, ay0;
  logic [COORD_W-1:0]      zabs0;
  logic                    neg0, zneg0, zero0, ear0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax0   <= tx;
      ay0   <= ty;
      neg0  <= s_neg;
      zabs0 <= sz[COORD_W-1:0];
      zneg0 <= req.pos_z < 0;
      zero0 <= (req.pos_x == 0) && (req.pos_y == 0) && (req.pos_z == 0);
      ear0  <= req.ear_sel;
    end
  end

  // azimuth cordic
  cordic_t ca [0:STEPS];
  assign ca[0].x   = CW'(ax0) <<< GUARD;
  assign ca[0].y   = CW'(ay0) <<< GUARD;
  assign ca[0].acc = '0;

  for (genvar i = 0; i < STEPS; i++) begin : g_az
    dthbi_cordic_stage u_stage (
      .clk  (clk),
      .en   (en),
      .step (STEP_W'(i)),
      .d_in (ca[i]),
      .d_out(ca[i+1])
    );
  end

  logic [COORD_W+30:0] zk_prod;
  assign zk_prod = zabs0 * GAIN_Q30;

  logic                 av    [1:STEPS];
  logic                 aneg  [1:STEPS];
  logic                 azneg [1:STEPS];
  logic                 azero [1:STEPS];
  logic                 aear  [1:STEPS];
  logic signed [CW-1:0] azk   [1:STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= STEPS; k++) av[k] <= 1'b0;
    end else if (en) begin
      av[1] <= v0;
      for (int k = 2; k <= STEPS; k++) av[k] <= av[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aneg[1]  <= neg0;
      azneg[1] <= zneg0;
      azero[1] <= zero0;
      aear[1]  <= ear0;
      azk[1]   <= CW'(zk_prod >> GAIN_SHIFT);
      for (int k = 2; k <= STEPS; k++) begin
        aneg[k]  <= aneg[k-1];
        azneg[k] <= azneg[k-1];
        azero[k] <= azero[k-1];
        aear[k]  <= aear[k-1];
        azk[k]   <= azk[k-1];
      end
    end
  end

  // azimuth rounding and wrap
  logic signed [AW-1:0] az_sum, az_rnd;
  always_comb begin
    az_sum = ca[STEPS].acc;
    if (aneg[STEPS]) begin
      az_sum = az_sum + (AW'(HALF_TURN) <<< ACC_FRAC);
    end
    az_rnd = round_ang(az_sum);
    if (az_rnd < 0) begin
      az_rnd = az_rnd + AW'(FULL);
    end
    if (az_rnd >= AW'(FULL)) begin
      az_rnd = az_rnd - AW'(FULL);
    end
  end

  logic                 rv, rzneg, rzero, rear;
  logic [AZW-1:0]       raz;
  logic signed [CW-1:0] rmx, rzk;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (en) begin
      rv <= av[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raz   <= az_rnd[AZW-1:0];
      rmx   <= ca[STEPS].x;
      rzk   <= azk[STEPS];
      rzneg <= azneg[STEPS];
      rzero <= azero[STEPS];
      rear  <= aear[STEPS];
    end
  end

  // elevation cordic
  cordic_t cb [0:STEPS];
  assign cb[0].x   = rmx;
  assign cb[0].y   = rzk;
  assign cb[0].acc = '0;

  for (genvar i = 0; i < STEPS; i++) begin : g_el
    dthbi_cordic_stage u_stage (
      .clk  (clk),
      .en   (en),
      .step (STEP_W'(i)),
      .d_in (cb[i]),
      .d_out(cb[i+1])
    );
  end

  logic           bv    [1:STEPS];
  logic           bzneg [1:STEPS];
  logic           bzero [1:STEPS];
  logic           bear  [1:STEPS];
  logic [AZW-1:0] baz   [1:STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= STEPS; k++) bv[k] <= 1'b0;
    end else if (en) begin
      bv[1] <= rv;
      for (int k = 2; k <= STEPS; k++) bv[k] <= bv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bzneg[1] <= rzneg;
      bzero[1] <= rzero;
      bear[1]  <= rear;
      baz[1]   <= raz;
      for (int k = 2; k <= STEPS; k++) begin
        bzneg[k] <= bzneg[k-1];
        bzero[k] <= bzero[k-1];
        bear[k]  <= bear[k-1];
        baz[k]   <= baz[k-1];
      end
    end
  end

  // elevation rounding
  logic signed [AW-1:0] el_rnd;
  always_comb begin
    el_rnd = round_ang(cb[STEPS].acc);
    if (bzneg[STEPS]) begin
      el_rnd = -el_rnd;
    end
  end

  logic                 e1v, e1zero, e1ear;
  logic signed [EW-1:0] e1el;
  logic [AZW-1:0]       e1az;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1v <= 1'b0;
    end else if (en) begin
      e1v <= bv[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1el   <= el_rnd[EW-1:0];
      e1az   <= baz[STEPS];
      e1zero <= bzero[STEPS];
      e1ear  <= bear[STEPS];
    end
  end

  // ring select: round(el / 10) + offset, saturated
  logic [EW-1:0]      el_mag;
  logic [EW-1:0]      el_t;
  logic [EW+3:0]      el_q5;
  logic signed [EW:0] ring_s;
  logic [RING_W-1:0]  ring_c;
  always_comb begin
    el_mag = e1el < 0 ? EW'(-e1el) : EW'(e1el);
    el_t   = (el_mag + EW'(TEN / 2)) >> (ANG_FRAC + 1);
    el_q5  = ((EW+4)'(el_t) * (EW+4)'(RECIP5)) >> RECIP5_SH;
    ring_s = (EW+1)'(el_q5);
    if (e1el < 0) begin
      ring_s = -ring_s;
    end
    ring_s = ring_s + (EW+1)'(RING_OFS);
    if (ring_s < 0) begin
      ring_c = '0;
    end else if (ring_s > (EW+1)'(NUM_RINGS - 1)) begin
      ring_c = RING_W'(NUM_RINGS - 1);
    end else begin
      ring_c = ring_s[RING_W-1:0];
    end
  end

  logic              e2v, e2zero, e2ear;
  logic [RING_W-1:0] e2ring;
  logic [AZW-1:0]    e2az;

  always_ff @(posedge clk) begin
    if (rst) begin
      e2v <= 1'b0;
    end else if (en) begin
      e2v <= e1v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2ring <= ring_c;
      e2az   <= e1az;
      e2zero <= e1zero;
      e2ear  <= e1ear;
    end
  end

  // 2*az*n + full
  logic [PROD_W-1:0] prod_c;
  assign prod_c = ((PROD_W'(e2az) * PROD_W'(ring_size(e2ring))) << 1) + PROD_W'(FULL);

  logic              mv, mzero, mear;
  logic [RING_W-1:0] mring;
  logic [PROD_W-1:0] mprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (en) begin
      mv <= e2v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mprod <= prod_c;
      mring <= e2ring;
      mzero <= e2zero;
      mear  <= e2ear;
    end
  end

  // divide by 2*full: shift then reciprocal of 45
  logic [Q_W-1:0]            dv;
  logic [Q_W+RECIP_SH-1:0]   dq_full;
  logic [AZI_W-1:0]          ai;
  logic [AZI_W-1:0]          n_m;
  always_comb begin
    dv      = mprod[PROD_W-1:DIV_SHIFT];
    dq_full = ((Q_W+RECIP_SH)'(dv) * (Q_W+RECIP_SH)'(RECIP45)) >> RECIP_SH;
    n_m     = ring_size(mring);
    ai      = dq_full[AZI_W-1:0];
    if (dq_full >= (Q_W+RECIP_SH)'(n_m)) begin
      ai = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.ear_out     <= mear;
      rsp.zero_vector <= mzero;
      if (mzero) begin
        rsp.elev_index   <= RING_W'(RING_OFS);
        rsp.azim_index   <= '0;
        rsp.entry_number <= ring_base(RING_W'(RING_OFS));
      end else begin
        rsp.elev_index   <= mring;
        rsp.azim_index   <= ai;
        rsp.entry_number <= ring_base(mring) + ENTRY_W'(ai);
      end
    end
  end

endmodule

// ===== rtl/dthbi_checker.sv =====
module dthbi_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [3:0] elev_index,
  input logic [6:0] azim_index,
  input logic [9:0] entry_number,
  input logic       zero_vector
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_number))
    else $error("stalled transaction changed");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && zero_vector |-> elev_index == 4'd4 && azim_index == 7'd0
      && entry_number == 10'd260)
    else $error("zero vector defaults wrong");

  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> elev_index <= 4'd13 && azim_index <= 7'd71 && entry_number <= 10'd709)
    else $error("index out of grid");

endmodule

bind direction_to_hrtf_bin_index dthbi_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .elev_index  (rsp.elev_index),
  .azim_index  (rsp.azim_index),
  .entry_number(rsp.entry_number),
  .zero_vector (rsp.zero_vector)
);

// ===== tb/direction_to_hrtf_bin_index_tb.sv =====
`timescale 1ns / 100ps

module direction_to_hrtf_bin_index_tb;
  import dthbi_pkg::*;

  typedef struct packed {
    logic               ear;
    logic [RING_W-1:0]  elev;
    logic [AZI_W-1:0]   azim;
    logic [ENTRY_W-1:0] entry;
    logic               zero;
  } grid_entry_t;

  localparam int LATENCY     = 54;
  localparam int IDLE_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1750;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  dthbi_req_if req ();
  dthbi_rsp_if rsp ();

  direction_to_hrtf_bin_index dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  grid_entry_t entries_due[$];
  logic        orient_mode;
  int          mismatches;
  int          idle_cycles;
  bit          hold_rsp;
  bit          failed;

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint cordic_angle(ref longint mag, input longint yin);
    longint atan_tab[24] = '{754974720, 445687602, 235489088, 119537938, 60000934,
      30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
      58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
    longint xv;
    longint yv;
    longint acc;
    longint dx;
    longint dy;
    xv = mag;
    yv = yin;
    acc = 0;
    for (int i = 0; i < 24; i++) begin
      dx = floor_shift(yv, i);
      dy = floor_shift(xv, i);
      if (yv >= 0) begin
        xv += dx; yv -= dy; acc += atan_tab[i];
      end else begin
        xv -= dx; yv += dy; acc -= atan_tab[i];
      end
    end
    mag = xv;
    return acc;
  endfunction

  function automatic longint round_deg(longint a);
    longint half;
    half = 64'sd1 <<< 15;
    if (a >= 0) return (a + half) >>> 16;
    return -(((-a) + half) >>> 16);
  endfunction

  function automatic grid_entry_t nearest_entry(logic signed [15:0] px, logic signed [15:0] py,
                                                logic signed [15:0] pz, logic ear_bit);
    int ring_n[14] = '{56, 60, 72, 72, 72, 72, 72, 60, 56, 45, 36, 24, 12, 1};
    int ring_start[14] = '{0, 56, 116, 188, 260, 332, 404, 476, 536, 592, 637, 673,
                           697, 709};
    grid_entry_t e;
    longint x, y, z, ax, ay, offs, mx, az, el, zk, full, ten, mag, q, ring, ai;
    x = px; y = py; z = pz;
    e.ear = ear_bit;
    if (x == 0 && y == 0 && z == 0) begin
      e.elev = 4; e.azim = 0; e.entry = 260; e.zero = 1'b1;
      return e;
    end
    if (orient_mode) begin
      ax = y; ay = -x;
    end else begin
      ax = x; ay = y;
    end
    offs = 0;
    if (ax < 0) begin
      ax = -ax; ay = -ay; offs = 64'sd180 <<< 24;
    end
    mx = ax <<< 20;
    az = round_deg(offs + cordic_angle(mx, ay <<< 20));
    full = 360 <<< 8;
    if (az < 0) az += full;
    if (az >= full) az -= full;
    zk = ((z < 0 ? -z : z) * 64'sd1768195363) >>> 10;
    el = round_deg(cordic_angle(mx, zk));
    if (z < 0) el = -el;
    ten = 10 <<< 8;
    mag = el < 0 ? -el : el;
    q = (2 * mag + ten) / (2 * ten);
    if (el < 0) q = -q;
    ring = q + 4;
    if (ring < 0) ring = 0;
    if (ring > 13) ring = 13;
    ai = (2 * az * ring_n[ring] + full) / (2 * full);
    if (ai >= ring_n[ring]) ai = 0;
    e.elev = ring[3:0];
    e.azim = ai[6:0];
    e.entry = 10'(ring_start[ring] + ai);
    e.zero = 1'b0;
    return e;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_direction(logic signed [15:0] px, logic signed [15:0] py,
                                logic signed [15:0] pz, logic ear_bit, bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 3) : 0;
    if ($urandom_range(0, 9) < 3) gap = 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.pos_x   <= px;
    req.pos_y   <= py;
    req.pos_z   <= pz;
    req.ear_sel <= ear_bit;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    entries_due.insert(entries_due.size(), nearest_entry(px, py, pz, ear_bit));
  endtask

  task automatic go_idle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (entries_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_orientation(logic mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
    orient_mode = mode;
  endtask

  task automatic send_random(int count);
    logic signed [15:0] px, py, pz;
    int shift;
    for (int i = 0; i < count; i++) begin
      px = 16'($urandom);
      py = 16'($urandom);
      pz = 16'($urandom);
      shift = $urandom_range(0, 15);
      case ($urandom_range(0, 5))
        0: begin
          px = px >>> shift; py = py >>> shift; pz = pz >>> shift;
        end
        1: pz = pz >>> shift;
        2: begin
          px = 0; py = 0;
        end
        3: pz = 0;
        default: ;
      endcase
      send_direction(px, py, pz, 1'($urandom));
    end
  endtask

  task automatic test_extremes();
    logic signed [15:0] vals[6] = '{16'sh8000, 16'sh7fff, 0, 1, -1, 16'sh4000};
    send_direction(0, 0, 0, 1'b0);
    send_direction(0, 0, 0, 1'b1);
    send_direction(0, 0, 16'sh7fff, 1'b0);
    send_direction(0, 0, 16'sh8000, 1'b1);
    send_direction(16'sh8000, 0, 0, 1'b0);
    send_direction(16'sh8000, -1, 0, 1'b1);
    send_direction(16'sh7fff, -1, 0, 1'b0);
    send_direction(0, 16'sh8000, 16'sh8000, 1'b1);
    send_direction(1000, 1000, 840, 1'b0);
    for (int i = 0; i < 6; i++)
      send_direction(vals[i], vals[5 - i], vals[(i + 2) % 6], 1'(i));
  endtask

  task automatic test_backpressure();
    hold_rsp = 1'b1;
    for (int i = 0; i < 90; i++)
      send_direction(16'($urandom), 16'($urandom), 16'($urandom >> 18), 1'($urandom), 0);
  endtask

  task automatic test_orientation();
    go_idle();
    set_orientation(1'b1);
    test_extremes();
    send_random(RANDOM_ITEMS / 2);
    go_idle();
    set_orientation(1'b0);
    send_random(RANDOM_ITEMS / 2);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    req.valid = 1'b0;
    req.pos_x = '0;
    req.pos_y = '0;
    req.pos_z = '0;
    req.ear_sel = 1'b0;
    orient_mode = 1'b0;
    hold_rsp = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_backpressure();
    test_orientation();
    go_idle();
    if (!failed && mismatches == 0 && entries_due.size() == 0) begin
      $display("direction_to_hrtf_bin_index_tb OK");
    end else begin
      $display("direction_to_hrtf_bin_index_tb NOT OK");
    end
    $finish;
  end

  initial begin
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (150) @(posedge clk);
        hold_rsp = 1'b0;
      end
      rsp.ready <= 1'b0;
      repeat ($urandom_range(0, 3)) @(posedge clk);
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(5, 40)) begin
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    grid_entry_t want;
    grid_entry_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{rsp.ear_out, rsp.elev_index, rsp.azim_index, rsp.entry_number,
              rsp.zero_vector};
      if (entries_due.size() == 0) begin
        failed <= 1'b1;
        if (mismatches < 10) $display("unexpected transaction %p", got);
        mismatches++;
      end else begin
        want = entries_due.pop_front();
        if (got !== want) begin
          if (mismatches < 10) $display("mismatch: expected %p actual %p", want, got);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("direction_to_hrtf_bin_index_tb NOT OK");
        $finish;
      end
    end
  end

endmodule
